### rtl/dorp_pkg.sv
// Package with the constants and word types of the delimited order record parser.
package dorp_pkg;

    // Number of fields parsed per record; later fields are ignored.
    localparam int FIELDS_PER_RECORD = 4;
    // Number of fields carried by a result word.
    localparam int OUT_FIELDS = 4;
    // Field index saturates at FIELDS_PER_RECORD, so it must be able to hold it.
    localparam int FIDX_W = $clog2(FIELDS_PER_RECORD + 1);
    localparam int VAL_W = 64;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_blob;
    } byte_item_t;

    typedef struct packed {
        logic        [VAL_W-1:0] order_id;
        logic signed [VAL_W-1:0] price;
        logic signed [VAL_W-1:0] leaves;
        logic        [VAL_W-1:0] sequence_res;
    } record_t;

endpackage

### rtl/delimited_order_record_parser_core.sv
// Top level of the delimited order record parser: byte-stream field parser with output skid.
//
// Usage: the byte channel (byte_valid, byte_ready, byte_word) carries one character of an
// order blob per word, with end_of_blob set on the final character. Records are separated
// by ';' and hold up to four ',' separated signed decimal fields (id, price, leaves, seq).
// The record channel (rec_valid, rec_ready, rec_word) delivers one word per non-empty
// record, when the record ends at ';' or at the end of the blob.
// Throughput is one byte word per cycle. The parse state is updated in the cycle a byte is
// accepted; a record's closing byte loads its result into the output register, or the skid
// register if that is held. The critical path is the multiply-by-ten and add of the current
// field, held as both its magnitude and its negation so that a sign costs only a select.
// Results pass through an output register backed by one skid register. byte_ready stays
// high while the skid register is empty, so bytes keep flowing while a result waits; if
// the receiver stalls long enough for both registers to fill, byte_ready drops until the
// output register is taken.
// Reset (rst_n low, asynchronous) clears all field values, returns the parser to the start
// of a record and empties both result registers. The parse state, but not the result
// registers, is cleared the same way after every end-of-blob byte, ready for the next blob.
module delimited_order_record_parser_core
    import dorp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  byte_item_t byte_word,
    output logic       rec_valid,
    input  logic       rec_ready,
    output record_t    rec_word
);

    // Parse state. Closed fields sit in fields_reg; the field being parsed is kept apart
    // as a magnitude and its two's complement, both updated on every digit that is taken.
    logic [VAL_W-1:0]  fields_reg [FIELDS_PER_RECORD];
    logic [VAL_W-1:0]  fields_next [FIELDS_PER_RECORD];
    logic [VAL_W-1:0]  mag_reg, mag_next;
    logic [VAL_W-1:0]  neg_reg, neg_next;
    logic [FIDX_W-1:0] idx_reg, idx_next;
    logic              at_start_reg, at_start_next;
    logic              negative_reg, negative_next;
    logic              stopped_reg, stopped_next;
    logic              has_bytes_reg, has_bytes_next;

    // Result registers: the output stage and its skid stage.
    record_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    record_t           skid_reg, skid_next;
    logic              skid_valid_reg, skid_valid_next;

    logic              accept;
    logic              rec_fire;
    logic [7:0]        ch;
    logic              active;
    logic              is_comma;
    logic              is_sign;
    logic              is_digit;
    logic              take_digit;
    logic [3:0]        digit;
    logic [VAL_W-1:0]  mag_upd;
    logic [VAL_W-1:0]  neg_upd;
    logic              negative_upd;
    logic [VAL_W-1:0]  cur_signed;
    logic              finish;
    logic              emit;
    logic [VAL_W-1:0]  rec_vals [OUT_FIELDS];
    record_t           rec_new;

    assign byte_ready = !skid_valid_reg;
    assign accept     = byte_valid && byte_ready;
    assign rec_valid  = out_valid_reg;
    assign rec_word   = out_reg;
    assign rec_fire   = out_valid_reg && rec_ready;

    // Byte classification and the update of the current field.
    always_comb
    begin
        ch         = byte_word.char_byte;
        active     = (idx_reg < FIDX_W'(FIELDS_PER_RECORD)) && (ch != CH_SEMI);
        is_comma   = (ch == CH_COMMA);
        is_sign    = at_start_reg && (ch inside {CH_MINUS, CH_PLUS});
        is_digit   = (ch inside {[CH_ZERO:CH_NINE]});
        digit      = 4'(ch - CH_ZERO);
        take_digit = active && !is_comma && !is_sign && !stopped_reg && is_digit;

        // Times ten as eight plus two; the negation follows the same recurrence.
        if (take_digit)
        begin
            mag_upd = (mag_reg << 3) + (mag_reg << 1) + VAL_W'(digit);
            neg_upd = (neg_reg << 3) + (neg_reg << 1) - VAL_W'(digit);
        end
        else
        begin
            mag_upd = mag_reg;
            neg_upd = neg_reg;
        end

        if (active && is_sign && !is_comma)
            negative_upd = (ch == CH_MINUS);
        else
            negative_upd = negative_reg;

        cur_signed = negative_upd ? neg_upd : mag_upd;
    end

    // The result word: the current field with its sign applied, the closed fields as
    // stored, and zero for fields past the configured count.
    for (genvar k = 0; k < OUT_FIELDS; k++)
    begin : g_rec
        if (k < FIELDS_PER_RECORD)
        begin : g_used
            assign rec_vals[k] = (idx_reg == FIDX_W'(k)) ? cur_signed : fields_reg[k];
        end
        else
        begin : g_unused
            assign rec_vals[k] = '0;
        end
    end

    always_comb
    begin
        rec_new.order_id     = rec_vals[0];
        rec_new.price        = rec_vals[1];
        rec_new.leaves       = rec_vals[2];
        rec_new.sequence_res = rec_vals[3];
    end

    // Next parse state.
    always_comb
    begin
        fields_next    = fields_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        idx_next       = idx_reg;
        at_start_next  = at_start_reg;
        negative_next  = negative_reg;
        stopped_next   = stopped_reg;
        has_bytes_next = has_bytes_reg;
        finish         = 1'b0;
        emit           = 1'b0;

        if (accept)
        begin
            finish = (ch == CH_SEMI) || byte_word.end_of_blob;
            if (ch != CH_SEMI)
                has_bytes_next = 1'b1;

            if (active)
            begin
                if (is_comma)
                begin
                    for (int k = 0; k < FIELDS_PER_RECORD; k++)
                    begin
                        if (idx_reg == FIDX_W'(k))
                            fields_next[k] = cur_signed;
                    end
                    idx_next      = idx_reg + FIDX_W'(1);
                    mag_next      = '0;
                    neg_next      = '0;
                    at_start_next = 1'b1;
                    negative_next = 1'b0;
                    stopped_next  = 1'b0;
                end
                else
                begin
                    mag_next      = mag_upd;
                    neg_next      = neg_upd;
                    negative_next = negative_upd;
                    at_start_next = 1'b0;
                    if (!is_sign && !stopped_reg && !is_digit)
                        stopped_next = 1'b1;
                end
            end

            if (finish)
            begin
                emit = has_bytes_next;
                for (int k = 0; k < FIELDS_PER_RECORD; k++)
                    fields_next[k] = '0;
                mag_next       = '0;
                neg_next       = '0;
                idx_next       = '0;
                at_start_next  = 1'b1;
                negative_next  = 1'b0;
                stopped_next   = 1'b0;
                has_bytes_next = 1'b0;
            end
        end
    end

    // Output register and skid register. A new record goes to the output register when
    // it is empty or being taken, otherwise it is parked in the skid register.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (skid_valid_reg)
        begin
            if (rec_fire)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (emit)
        begin
            if (!out_valid_reg || rec_fire)
            begin
                out_next       = rec_new;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = rec_new;
                skid_valid_next = 1'b1;
            end
        end
        else if (rec_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FIELDS_PER_RECORD; k++)
                fields_reg[k] <= '0;
            mag_reg        <= '0;
            neg_reg        <= '0;
            idx_reg        <= '0;
            at_start_reg   <= 1'b1;
            negative_reg   <= 1'b0;
            stopped_reg    <= 1'b0;
            has_bytes_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            fields_reg     <= fields_next;
            mag_reg        <= mag_next;
            neg_reg        <= neg_next;
            idx_reg        <= idx_next;
            at_start_reg   <= at_start_next;
            negative_reg   <= negative_next;
            stopped_reg    <= stopped_next;
            has_bytes_reg  <= has_bytes_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTHESIS
    // The skid register only ever fills behind a held output word.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a record while the output register is empty");

    // The field index never passes the saturation point.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= FIDX_W'(FIELDS_PER_RECORD))
        else $error("field index beyond the field count");

    // A final byte other than ';' always closes a non-empty record and restarts parsing.
    a_blob_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_word.end_of_blob && (byte_word.char_byte != CH_SEMI))
        |=> (rec_valid && (idx_reg == '0) && at_start_reg && !has_bytes_reg))
        else $error("end of blob did not deliver a record and restart the parser");
`endif

endmodule
